[rtl/stk_pkg.sv]
// Shared types, constants and helper functions of the source tokenizer.
// Used by every module under rtl/; depends on nothing.
package stk_pkg;

    // Internal counter widths
    localparam int OFFSET_BITS = 20;
    localparam int LINE_BITS   = 16;

    // Result field widths
    localparam int KIND_W  = 5;
    localparam int ERR_W   = 2;
    localparam int START_W = 20;
    localparam int LEN_W   = 20;
    localparam int LINE_W  = 16;

    localparam int OFF_EXT_W  = (OFFSET_BITS + 1 > START_W) ? OFFSET_BITS + 1 : START_W;
    localparam int LINE_EXT_W = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [OFFSET_BITS:0]   OFF_ONE  = (OFFSET_BITS + 1)'(1);

    // Results per input item and the queue between front and back
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int TOK_IDX_W   = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Token kinds
    localparam logic [KIND_W-1:0] K_LPAREN        = 5'd0;
    localparam logic [KIND_W-1:0] K_RPAREN        = 5'd1;
    localparam logic [KIND_W-1:0] K_LBRACE        = 5'd2;
    localparam logic [KIND_W-1:0] K_RBRACE        = 5'd3;
    localparam logic [KIND_W-1:0] K_COMMA         = 5'd4;
    localparam logic [KIND_W-1:0] K_DOT           = 5'd5;
    localparam logic [KIND_W-1:0] K_MINUS         = 5'd6;
    localparam logic [KIND_W-1:0] K_PLUS          = 5'd7;
    localparam logic [KIND_W-1:0] K_SEMICOLON     = 5'd8;
    localparam logic [KIND_W-1:0] K_STAR          = 5'd9;
    localparam logic [KIND_W-1:0] K_BANG          = 5'd10;
    localparam logic [KIND_W-1:0] K_EQUAL         = 5'd12;
    localparam logic [KIND_W-1:0] K_LESS          = 5'd14;
    localparam logic [KIND_W-1:0] K_GREATER       = 5'd16;
    localparam logic [KIND_W-1:0] K_SLASH         = 5'd18;
    localparam logic [KIND_W-1:0] K_STRING        = 5'd19;
    localparam logic [KIND_W-1:0] K_NUMBER        = 5'd20;
    localparam logic [KIND_W-1:0] K_IDENT         = 5'd21;
    localparam logic [KIND_W-1:0] K_EOF           = 5'd22;
    localparam logic [KIND_W-1:0] K_ERROR         = 5'd23;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 2'd2;

    // Characters
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;

    typedef enum logic [3:0] {
        M_IDLE     = 4'd0,
        M_BANG     = 4'd1,
        M_EQUAL    = 4'd2,
        M_LESS     = 4'd3,
        M_GREATER  = 4'd4,
        M_SLASH    = 4'd5,
        M_COMMENT  = 4'd6,
        M_STRING   = 4'd7,
        M_NUMBER   = 4'd8,
        M_NUMDOT   = 4'd9,
        M_FRACTION = 4'd10,
        M_IDENT    = 4'd11
    } scan_mode_t;

    typedef struct packed {
        logic       op;
        logic [7:0] source_byte;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [ERR_W-1:0]   error_code;
        logic [START_W-1:0] start_offset;
        logic [LEN_W-1:0]   lexeme_length;
        logic [LINE_W-1:0]  line_number;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ERR_W-1:0]   err;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } tok_t;

    // All results of one input item; they share one line value
    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        logic [LINE_W-1:0]            line_number;
        tok_t [MAX_RESULTS-1:0]       tok;
    } record_t;

    typedef struct packed {
        logic    push;
        record_t rec;
    } queue_wr_t;

    typedef struct packed {
        logic    valid;
        record_t head;
    } queue_rd_t;

    typedef struct packed {
        logic       hit;
        logic [KIND_W-1:0] kind;
    } punct_t;

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_decimal(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
    endfunction

    function automatic punct_t punct_lookup(input logic [7:0] c);
        punct_t r;
        r.hit  = 1'b1;
        r.kind = K_LPAREN;
        case (c)
            8'h28: r.kind = K_LPAREN;
            8'h29: r.kind = K_RPAREN;
            8'h7B: r.kind = K_LBRACE;
            8'h7D: r.kind = K_RBRACE;
            8'h2C: r.kind = K_COMMA;
            8'h2E: r.kind = K_DOT;
            8'h2D: r.kind = K_MINUS;
            8'h2B: r.kind = K_PLUS;
            8'h3B: r.kind = K_SEMICOLON;
            8'h2A: r.kind = K_STAR;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] pair_base(input scan_mode_t m);
        logic [KIND_W-1:0] k;
        case (m)
            M_BANG:    k = K_BANG;
            M_EQUAL:   k = K_EQUAL;
            M_LESS:    k = K_LESS;
            M_GREATER: k = K_GREATER;
            default:   k = K_BANG;
        endcase
        return k;
    endfunction

    function automatic logic [OFFSET_BITS:0] sat_sub(input logic [OFFSET_BITS:0] a,
                                                     input logic [OFFSET_BITS:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [START_W-1:0] fit_off(input logic [OFFSET_BITS:0] v);
        logic [OFF_EXT_W-1:0] x;
        x = OFF_EXT_W'(v);
        return x[START_W-1:0];
    endfunction

    function automatic logic [LINE_W-1:0] fit_line(input logic [LINE_BITS-1:0] v);
        logic [LINE_EXT_W-1:0] x;
        x = LINE_EXT_W'(v);
        return x[LINE_W-1:0];
    endfunction

    function automatic tok_t make_tok(input logic [KIND_W-1:0] kind,
                                      input logic [ERR_W-1:0] err,
                                      input logic [OFFSET_BITS:0] start,
                                      input logic [OFFSET_BITS:0] len);
        tok_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = fit_off(start);
        t.len   = fit_off(len);
        return t;
    endfunction

    function automatic record_t append(input record_t r, input tok_t t);
        record_t o;
        o = r;
        o.tok[r.count[TOK_IDX_W-1:0]] = t;
        o.count = r.count + RES_CNT_W'(1);
        return o;
    endfunction

endpackage

[rtl/source_tokenizer_core.sv]
// Source tokenizer top level: scanner front, record queue and serializer.
// Depends on stk_pkg, stk_front, stk_queue and stk_back.
//
// Input channel s_*: one source byte per transaction (op = 0), or an end
// marker (op = 1) that flushes the pending lexeme and adds an end-of-file
// token. Result channel m_*: one token per transaction; last_of_run marks
// the final token caused by one input transaction.
// Tokens of an accepted byte are written into the registered record queue
// and presented from its head. A byte is scanned in the cycle it is accepted.
// Throughput: one input per cycle while m_ready is high and each input yields
// at most one token; an input that yields up to 3 tokens sends them one per
// result transaction. Inputs that yield nothing pass without touching the channel.
// A two-record queue parts the scanner from the serializer, so s_ready
// stays high while results wait; when m_ready is low the queue fills and
// s_ready drops once it holds two records.
// Reset: offset and token start return to 0, line to 1, the scan state to
// idle and the queue empties. After each end marker the scan state returns
// to that same point, so the next byte begins a new source.
module source_tokenizer_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  stk_pkg::item_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output stk_pkg::result_t m_data
);

    stk_pkg::queue_wr_t wr;
    stk_pkg::queue_rd_t rd;
    logic               full;
    logic               pop;
    logic               accept;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    stk_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .wr      (wr)
    );

    stk_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .pop     (pop),
        .full    (full),
        .rd      (rd)
    );

    stk_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rd),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/stk_front.sv]
// Scanner front end: accepts source bytes, runs the scan state machine and
// packs the tokens of each byte into one record. Depends on stk_pkg.
module stk_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  stk_pkg::item_t     item,
    output stk_pkg::queue_wr_t wr
);

    stk_pkg::scan_mode_t                mode_reg, mode_next;
    logic [stk_pkg::OFFSET_BITS-1:0]    off_reg, off_next;
    logic [stk_pkg::OFFSET_BITS-1:0]    ts_reg, ts_next;
    logic [stk_pkg::LINE_BITS-1:0]      line_reg, line_next;

    stk_pkg::record_t                   rec;
    stk_pkg::punct_t                    pk;
    logic                               consumed;
    logic [7:0]                         b;
    logic [stk_pkg::OFFSET_BITS:0]      p_ext, p1_ext, pm1_ext, ts_ext;
    logic [stk_pkg::LINE_BITS-1:0]      line_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= stk_pkg::M_IDLE;
            off_reg  <= '0;
            ts_reg   <= '0;
            line_reg <= stk_pkg::LINE_BITS'(1);
        end else if (accept) begin
            mode_reg <= mode_next;
            off_reg  <= off_next;
            ts_reg   <= ts_next;
            line_reg <= line_next;
        end
    end

    always_comb begin
        b        = item.source_byte;
        p_ext    = {1'b0, off_reg};
        ts_ext   = {1'b0, ts_reg};
        p1_ext   = p_ext + stk_pkg::OFF_ONE;
        pm1_ext  = stk_pkg::sat_sub(p_ext, stk_pkg::OFF_ONE);
        line_inc = (line_reg == stk_pkg::LINE_MAX) ? line_reg
                                                   : line_reg + stk_pkg::LINE_BITS'(1);
        pk       = stk_pkg::punct_lookup(b);

        rec             = '0;
        rec.line_number = stk_pkg::fit_line(line_reg);
        consumed        = 1'b0;
        mode_next       = mode_reg;
        off_next        = off_reg;
        ts_next         = ts_reg;
        line_next       = line_reg;

        if (item.op == stk_pkg::OP_END) begin
            // Flush the pending lexeme, then close the source
            case (mode_reg)
                stk_pkg::M_BANG, stk_pkg::M_EQUAL, stk_pkg::M_LESS,
                stk_pkg::M_GREATER: begin
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        stk_pkg::pair_base(mode_reg), stk_pkg::ERR_NONE, ts_ext,
                        stk_pkg::sat_sub(p_ext, ts_ext)));
                end
                stk_pkg::M_SLASH: begin
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        stk_pkg::K_SLASH, stk_pkg::ERR_NONE, ts_ext,
                        stk_pkg::sat_sub(p_ext, ts_ext)));
                end
                stk_pkg::M_STRING: begin
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        stk_pkg::K_ERROR, stk_pkg::ERR_UNTERMINATED, ts_ext,
                        stk_pkg::sat_sub(p_ext, ts_ext)));
                end
                stk_pkg::M_NUMBER, stk_pkg::M_FRACTION: begin
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        stk_pkg::K_NUMBER, stk_pkg::ERR_NONE, ts_ext,
                        stk_pkg::sat_sub(p_ext, ts_ext)));
                end
                stk_pkg::M_NUMDOT: begin
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        stk_pkg::K_NUMBER, stk_pkg::ERR_NONE, ts_ext,
                        stk_pkg::sat_sub(pm1_ext, ts_ext)));
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        stk_pkg::K_DOT, stk_pkg::ERR_NONE, pm1_ext, stk_pkg::OFF_ONE));
                end
                stk_pkg::M_IDENT: begin
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        stk_pkg::K_IDENT, stk_pkg::ERR_NONE, ts_ext,
                        stk_pkg::sat_sub(p_ext, ts_ext)));
                end
                default: ;
            endcase
            rec = stk_pkg::append(rec, stk_pkg::make_tok(
                stk_pkg::K_EOF, stk_pkg::ERR_NONE, p_ext, '0));
            mode_next = stk_pkg::M_IDLE;
            off_next  = '0;
            ts_next   = '0;
            line_next = stk_pkg::LINE_BITS'(1);
        end else begin
            // Continue the pending lexeme
            case (mode_reg)
                stk_pkg::M_BANG, stk_pkg::M_EQUAL, stk_pkg::M_LESS,
                stk_pkg::M_GREATER: begin
                    mode_next = stk_pkg::M_IDLE;
                    if (b == stk_pkg::CH_EQUAL) begin
                        consumed = 1'b1;
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::pair_base(mode_reg) + stk_pkg::KIND_W'(1),
                            stk_pkg::ERR_NONE, ts_ext, stk_pkg::sat_sub(p1_ext, ts_ext)));
                    end else begin
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::pair_base(mode_reg), stk_pkg::ERR_NONE, ts_ext,
                            stk_pkg::sat_sub(p_ext, ts_ext)));
                    end
                end
                stk_pkg::M_SLASH: begin
                    if (b == stk_pkg::CH_SLASH) begin
                        consumed  = 1'b1;
                        mode_next = stk_pkg::M_COMMENT;
                    end else begin
                        mode_next = stk_pkg::M_IDLE;
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::K_SLASH, stk_pkg::ERR_NONE, ts_ext,
                            stk_pkg::sat_sub(p_ext, ts_ext)));
                    end
                end
                stk_pkg::M_COMMENT: begin
                    // Leave the newline for the idle path so it counts as a line break
                    if (b == stk_pkg::CH_NEWLINE) begin
                        mode_next = stk_pkg::M_IDLE;
                    end else begin
                        consumed = 1'b1;
                    end
                end
                stk_pkg::M_STRING: begin
                    consumed = 1'b1;
                    if (b == stk_pkg::CH_QUOTE) begin
                        mode_next = stk_pkg::M_IDLE;
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::K_STRING, stk_pkg::ERR_NONE, ts_ext,
                            stk_pkg::sat_sub(p1_ext, ts_ext)));
                    end else if (b == stk_pkg::CH_NEWLINE) begin
                        line_next = line_inc;
                    end
                end
                stk_pkg::M_NUMBER: begin
                    if (stk_pkg::is_decimal(b)) begin
                        consumed = 1'b1;
                    end else if (b == stk_pkg::CH_DOT) begin
                        consumed  = 1'b1;
                        mode_next = stk_pkg::M_NUMDOT;
                    end else begin
                        mode_next = stk_pkg::M_IDLE;
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::K_NUMBER, stk_pkg::ERR_NONE, ts_ext,
                            stk_pkg::sat_sub(p_ext, ts_ext)));
                    end
                end
                stk_pkg::M_NUMDOT: begin
                    if (stk_pkg::is_decimal(b)) begin
                        consumed  = 1'b1;
                        mode_next = stk_pkg::M_FRACTION;
                    end else begin
                        // Release the held dot as a token of its own
                        mode_next = stk_pkg::M_IDLE;
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::K_NUMBER, stk_pkg::ERR_NONE, ts_ext,
                            stk_pkg::sat_sub(pm1_ext, ts_ext)));
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::K_DOT, stk_pkg::ERR_NONE, pm1_ext, stk_pkg::OFF_ONE));
                    end
                end
                stk_pkg::M_FRACTION: begin
                    if (stk_pkg::is_decimal(b)) begin
                        consumed = 1'b1;
                    end else begin
                        mode_next = stk_pkg::M_IDLE;
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::K_NUMBER, stk_pkg::ERR_NONE, ts_ext,
                            stk_pkg::sat_sub(p_ext, ts_ext)));
                    end
                end
                stk_pkg::M_IDENT: begin
                    if (stk_pkg::is_alnum(b)) begin
                        consumed = 1'b1;
                    end else begin
                        mode_next = stk_pkg::M_IDLE;
                        rec = stk_pkg::append(rec, stk_pkg::make_tok(
                            stk_pkg::K_IDENT, stk_pkg::ERR_NONE, ts_ext,
                            stk_pkg::sat_sub(p_ext, ts_ext)));
                    end
                end
                default: begin
                    mode_next = stk_pkg::M_IDLE;
                end
            endcase

            // Start a new lexeme with this byte
            if (!consumed) begin
                ts_next   = off_reg;
                mode_next = stk_pkg::M_IDLE;
                if (pk.hit) begin
                    rec = stk_pkg::append(rec, stk_pkg::make_tok(
                        pk.kind, stk_pkg::ERR_NONE, p_ext, stk_pkg::OFF_ONE));
                end else begin
                    case (b)
                        stk_pkg::CH_BANG:    mode_next = stk_pkg::M_BANG;
                        stk_pkg::CH_EQUAL:   mode_next = stk_pkg::M_EQUAL;
                        stk_pkg::CH_LESS:    mode_next = stk_pkg::M_LESS;
                        stk_pkg::CH_GREATER: mode_next = stk_pkg::M_GREATER;
                        stk_pkg::CH_SLASH:   mode_next = stk_pkg::M_SLASH;
                        stk_pkg::CH_SPACE, stk_pkg::CH_CR, stk_pkg::CH_TAB: ;
                        stk_pkg::CH_NEWLINE: line_next = line_inc;
                        stk_pkg::CH_QUOTE:   mode_next = stk_pkg::M_STRING;
                        default: begin
                            if (stk_pkg::is_decimal(b)) begin
                                mode_next = stk_pkg::M_NUMBER;
                            end else if (stk_pkg::is_alnum(b)) begin
                                mode_next = stk_pkg::M_IDENT;
                            end else begin
                                rec = stk_pkg::append(rec, stk_pkg::make_tok(
                                    stk_pkg::K_ERROR, stk_pkg::ERR_UNEXPECTED, p_ext,
                                    stk_pkg::OFF_ONE));
                            end
                        end
                    endcase
                end
            end

            off_next = (off_reg == stk_pkg::OFF_MAX) ? off_reg
                                                     : off_reg + stk_pkg::OFFSET_BITS'(1);
        end

        wr.push = accept && (rec.count != '0);
        wr.rec  = rec;
    end

    // The token start never runs ahead of the current offset
    a_start_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        ts_reg <= off_reg)
        else $error("token start ahead of current offset");

endmodule

[rtl/stk_queue.sv]
// Short record queue between the scanner front and the token serializer.
// Register storage, one write and one read port. Depends on stk_pkg.
module stk_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  stk_pkg::queue_wr_t wr,
    input  logic               pop,
    output logic               full,
    output stk_pkg::queue_rd_t rd
);

    stk_pkg::record_t               mem_reg [stk_pkg::QUEUE_DEPTH];
    logic [stk_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [stk_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [stk_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    always_comb begin
        full     = (count_reg == stk_pkg::QCNT_W'(stk_pkg::QUEUE_DEPTH));
        rd.valid = (count_reg != '0);
        rd.head  = mem_reg[rd_ptr_reg];
        do_push  = wr.push && !full;
        do_pop   = pop && rd.valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == stk_pkg::QPTR_W'(stk_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + stk_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == stk_pkg::QPTR_W'(stk_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + stk_pkg::QPTR_W'(1);
        end
        count_next = count_reg + stk_pkg::QCNT_W'(do_push) - stk_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr.rec;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.push |-> !full)
        else $error("record pushed into a full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= stk_pkg::QCNT_W'(stk_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd.valid |-> (rd.head.count != '0))
        else $error("queued record holds no tokens");

endmodule

[rtl/stk_back.sv]
// Token serializer: walks the tokens of the queue head one per cycle while
// m_ready is high and presents them on the result channel. Depends on stk_pkg.
module stk_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  stk_pkg::queue_rd_t rd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output stk_pkg::result_t   m_data
);

    logic [stk_pkg::TOK_IDX_W-1:0] idx_reg, idx_next;
    stk_pkg::tok_t                 cur;
    logic                          last;

    always_comb begin
        cur     = rd.head.tok[idx_reg];
        last    = (stk_pkg::RES_CNT_W'(idx_reg) + stk_pkg::RES_CNT_W'(1)) == rd.head.count;
        m_valid = rd.valid;

        m_data.token_kind    = cur.kind;
        m_data.error_code    = cur.err;
        m_data.start_offset  = cur.start;
        m_data.lexeme_length = cur.len;
        m_data.line_number   = rd.head.line_number;
        m_data.last_of_run   = last;

        // Advance within the record; drop it after its last token
        pop      = m_valid && m_ready && last;
        idx_next = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = last ? '0 : idx_reg + stk_pkg::TOK_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    a_idx_in_record: assert property (@(posedge aclk) disable iff (!aresetn)
        rd.valid |-> (stk_pkg::RES_CNT_W'(idx_reg) < rd.head.count))
        else $error("token index beyond queued record");

endmodule
